### rtl/skt_pkg.sv
package skt_pkg;

    localparam int KEY_W  = 64;
    localparam int VAL_W  = 64;
    localparam int HELD_W = 7;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_FIND   = 2'd1,
        OP_DELETE = 2'd2,
        OP_LIST   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_TOP,
        PTR_INC,
        PTR_DEC
    } ptr_op_t;

    typedef enum logic [1:0] {
        WA_NEXT,
        WA_PREV,
        WA_ZERO
    } wr_addr_sel_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef struct packed {
        logic         take_in;
        ptr_op_t      ptr_op;
        logic         rd_en;
        logic         wr_en;
        logic         wr_new;
        wr_addr_sel_t wr_sel;
        logic         emit;
        status_t      status;
        logic         use_data;
        logic         last;
        cnt_op_t      cnt_op;
    } skt_cmd_t;

    typedef struct packed {
        logic in_valid;
        op_t  op;
        logic empty;
        logic full;
        logic key_gt;
        logic key_eq;
        logic has_next;
        logic ptr_zero;
        logic slot_free;
    } skt_sts_t;

endpackage

### rtl/skt_intf.sv
interface skt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [63:0] key;
    logic [63:0] value;

    modport source (output valid, output operation, output key, output value, input ready);
    modport sink (input valid, input operation, input key, input value, output ready);
endinterface

interface skt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] entry_key;
    logic [63:0] entry_value;
    logic [6:0]  entries_held;
    logic        last;

    modport source (output valid, output status, output entry_key, output entry_value,
                    output entries_held, output last, input ready);
    modport sink (input valid, input status, input entry_key, input entry_value,
                  input entries_held, input last, output ready);
endinterface

### rtl/skt_ram.sv
module skt_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/skt_datapath.sv
module skt_datapath import skt_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    skt_in_if.sink    request,
    skt_out_if.source reply,
    input  skt_cmd_t  cmd,
    output skt_sts_t  sts
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int RW = KEY_W + VAL_W;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    op_t              op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] value_reg;
    logic [AW-1:0]    ptr_reg;
    logic [AW-1:0]    ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    logic              res_valid_reg;
    status_t           res_status_reg;
    logic [KEY_W-1:0]  res_key_reg;
    logic [VAL_W-1:0]  res_value_reg;
    logic [HELD_W-1:0] res_held_reg;
    logic              res_last_reg;

    logic [AW-1:0]    wr_addr;
    logic [RW-1:0]    wr_data;
    logic [RW-1:0]    rd_data;
    logic [KEY_W-1:0] rd_key;
    logic [VAL_W-1:0] rd_value;
    logic             slot_free;

    assign rd_key   = rd_data[RW-1:VAL_W];
    assign rd_value = rd_data[VAL_W-1:0];
    assign wr_data  = cmd.wr_new ? {key_reg, value_reg} : rd_data;
    assign slot_free = !res_valid_reg || reply.ready;

    always_comb
    begin
        unique case (cmd.ptr_op)
            PTR_HOLD: ptr_next = ptr_reg;
            PTR_ZERO: ptr_next = '0;
            PTR_TOP:  ptr_next = AW'(count_reg - CW'(1));
            PTR_INC:  ptr_next = ptr_reg + AW'(1);
            PTR_DEC:  ptr_next = ptr_reg - AW'(1);
            default:  ptr_next = ptr_reg;
        endcase
    end

    always_comb
    begin
        unique case (cmd.wr_sel)
            WA_NEXT: wr_addr = ptr_reg + AW'(1);
            WA_PREV: wr_addr = ptr_reg - AW'(1);
            WA_ZERO: wr_addr = '0;
            default: wr_addr = ptr_reg;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.emit)
        begin
            unique case (cmd.cnt_op)
                CNT_HOLD: count_next = count_reg;
                CNT_INC:  count_next = count_reg + CW'(1);
                CNT_DEC:  count_next = count_reg - CW'(1);
                default:  count_next = count_reg;
            endcase
        end
    end

    skt_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (ptr_next),
        .rd_data (rd_data)
    );

    assign sts.in_valid  = request.valid;
    assign sts.op        = op_reg;
    assign sts.empty     = (count_reg == '0);
    assign sts.full      = (count_reg == FULL_CNT);
    assign sts.key_gt    = (rd_key > key_reg);
    assign sts.key_eq    = (rd_key == key_reg);
    assign sts.has_next  = ((CW'(ptr_reg) + CW'(1)) < count_reg);
    assign sts.ptr_zero  = (ptr_reg == '0);
    assign sts.slot_free = slot_free;

    assign request.ready      = cmd.take_in;
    assign reply.valid        = res_valid_reg;
    assign reply.status       = res_status_reg;
    assign reply.entry_key    = res_key_reg;
    assign reply.entry_value  = res_value_reg;
    assign reply.entries_held = res_held_reg;
    assign reply.last         = res_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (reply.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        if (cmd.take_in && request.valid)
        begin
            op_reg    <= op_t'(request.operation);
            key_reg   <= request.key;
            value_reg <= request.value;
        end
        if (cmd.emit)
        begin
            res_status_reg <= cmd.status;
            res_key_reg    <= cmd.use_data ? rd_key : '0;
            res_value_reg  <= cmd.use_data ? rd_value : '0;
            res_held_reg   <= HELD_W'(count_next);
            res_last_reg   <= cmd.last;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count above depth");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> (CW'(wr_addr) <= count_reg))
        else $error("store write beyond occupied range");

    a_no_grow_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.cnt_op == CNT_INC) |-> (count_reg != FULL_CNT))
        else $error("insert completed on a full table");

endmodule

### rtl/skt_ctrl.sv
module skt_ctrl import skt_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  skt_sts_t sts,
    output skt_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_INS_WALK,
        S_INS_PUT,
        S_SCAN,
        S_DEL_SHIFT,
        S_LIST
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        cmd.last   = 1'b1;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.take_in = 1'b1;
                if (sts.in_valid)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                unique case (sts.op)
                    OP_INSERT:
                    begin
                        if (sts.full)
                        begin
                            if (sts.slot_free)
                            begin
                                cmd.emit   = 1'b1;
                                cmd.status = ST_FULL;
                                state_next = S_IDLE;
                            end
                        end
                        else if (sts.empty)
                        begin
                            state_next = S_INS_PUT;
                        end
                        else
                        begin
                            cmd.ptr_op = PTR_TOP;
                            cmd.rd_en  = 1'b1;
                            state_next = S_INS_WALK;
                        end
                    end
                    OP_FIND, OP_DELETE:
                    begin
                        if (sts.empty)
                        begin
                            if (sts.slot_free)
                            begin
                                cmd.emit   = 1'b1;
                                cmd.status = ST_MISSING;
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.ptr_op = PTR_ZERO;
                            cmd.rd_en  = 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                    OP_LIST:
                    begin
                        if (sts.empty)
                        begin
                            if (sts.slot_free)
                            begin
                                cmd.emit   = 1'b1;
                                cmd.status = ST_EMPTY;
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.ptr_op = PTR_ZERO;
                            cmd.rd_en  = 1'b1;
                            state_next = S_LIST;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_INS_WALK:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WA_NEXT;
                if (sts.key_gt)
                begin
                    // shift the larger entry up one place
                    if (sts.ptr_zero)
                    begin
                        state_next = S_INS_PUT;
                    end
                    else
                    begin
                        cmd.ptr_op = PTR_DEC;
                        cmd.rd_en  = 1'b1;
                    end
                end
                else
                begin
                    cmd.wr_new = 1'b1;
                    if (sts.slot_free)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.status = ST_OK;
                        cmd.cnt_op = CNT_INC;
                        state_next = S_IDLE;
                    end
                end
            end
            S_INS_PUT:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_new = 1'b1;
                cmd.wr_sel = WA_ZERO;
                if (sts.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.status = ST_OK;
                    cmd.cnt_op = CNT_INC;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (sts.key_eq)
                begin
                    if (sts.op == OP_FIND)
                    begin
                        if (sts.slot_free)
                        begin
                            cmd.emit     = 1'b1;
                            cmd.status   = ST_OK;
                            cmd.use_data = 1'b1;
                            state_next   = S_IDLE;
                        end
                    end
                    else if (sts.has_next)
                    begin
                        cmd.ptr_op = PTR_INC;
                        cmd.rd_en  = 1'b1;
                        state_next = S_DEL_SHIFT;
                    end
                    else if (sts.slot_free)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.status = ST_OK;
                        cmd.cnt_op = CNT_DEC;
                        state_next = S_IDLE;
                    end
                end
                else if (sts.has_next)
                begin
                    cmd.ptr_op = PTR_INC;
                    cmd.rd_en  = 1'b1;
                end
                else if (sts.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.status = ST_MISSING;
                    state_next = S_IDLE;
                end
            end
            S_DEL_SHIFT:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WA_PREV;
                if (sts.has_next)
                begin
                    cmd.ptr_op = PTR_INC;
                    cmd.rd_en  = 1'b1;
                end
                else if (sts.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.status = ST_OK;
                    cmd.cnt_op = CNT_DEC;
                    state_next = S_IDLE;
                end
            end
            S_LIST:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.status   = ST_OK;
                    cmd.use_data = 1'b1;
                    cmd.last     = !sts.has_next;
                    if (sts.has_next)
                    begin
                        cmd.ptr_op = PTR_INC;
                        cmd.rd_en  = 1'b1;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.slot_free)
        else $error("result loaded over a waiting result");

    a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN || state_reg == S_LIST || state_reg == S_DEL_SHIFT)
        |-> !sts.empty)
        else $error("table walk on an empty table");

    a_shift_above_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DEL_SHIFT) |-> !sts.ptr_zero)
        else $error("delete shift from entry zero");

endmodule

### rtl/sorted_key_value_table.sv
// channel   dir  payload                                          handshake
// request   in   operation[1:0] key[63:0] value[63:0]              valid/ready
// reply     out  status[1:0] entry_key[63:0] entry_value[63:0]     valid/ready
//                entries_held[6:0] last
//
// One item at a time; the store is one RAM, one read and one write per cycle.
// Insert shifts larger entries up from the top; find scans from entry zero;
// delete shifts the entries after the match down; list replies once per entry.
// Reset clears the entry count and result valid; the store is not cleared.
// A stalled reply holds the result register; a new request is taken meanwhile.
module sorted_key_value_table import skt_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    skt_in_if.sink    request,
    skt_out_if.source reply
);

    skt_cmd_t cmd;
    skt_sts_t sts;

    skt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    skt_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .reply   (reply),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule

### tb/tb_sorted_key_value_table.sv
module tb_sorted_key_value_table;
    timeunit 1ns;
    timeprecision 1ps;

    import skt_pkg::*;

    localparam int DEPTH      = 16;
    localparam int RAND_ITEMS = 250;
    localparam int QUIET_MAX  = 4000;
    localparam int NPLAN      = 17;

    localparam logic [63:0] NAME_JOHN = 64'h4A4F_484E_0000_0000;
    localparam logic [63:0] NAME_MA   = 64'h4D41_0000_0000_0000;
    localparam logic [63:0] NAME_ZZ   = 64'h5A5A_0000_0000_0000;
    localparam logic [63:0] KEY_MAX   = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] PHONE_A   = 64'h3535_3531_3233_3400;
    localparam logic [63:0] PHONE_B   = 64'h3535_3539_3837_3600;

    typedef struct packed {
        status_t     status;
        logic [63:0] entry_key;
        logic [63:0] entry_value;
        logic [6:0]  entries_held;
        logic        last;
    } reply_t;

    typedef struct packed {
        op_t         op;
        logic [63:0] key;
        logic [63:0] value;
        logic [4:0]  reps;
        logic        typed;
        status_t     want_status;
        logic [6:0]  want_held;
    } step_t;

    logic clk = 1'b0;
    logic rst_n;

    skt_in_if  req();
    skt_out_if rep();

    sorted_key_value_table #(.DEPTH(DEPTH)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req),
        .reply   (rep)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // shadow copy of the table
    logic [63:0] tbl_key [DEPTH];
    logic [63:0] tbl_val [DEPTH];
    int          tbl_held;

    reply_t due_replies[$];

    int errors;
    int replies_checked;
    int op_count [4];
    int seen_full;
    int seen_missing;
    int seen_empty;
    int items_sent;
    int send_calm;
    int sink_calm;
    int stall_left;
    int quiet;

    step_t plan [NPLAN] = '{
        '{OP_LIST,   64'd0,     64'd0,   5'd1,  1'b1, ST_EMPTY,   7'd0},
        '{OP_FIND,   NAME_JOHN, 64'd0,   5'd1,  1'b1, ST_MISSING, 7'd0},
        '{OP_DELETE, NAME_JOHN, 64'd0,   5'd1,  1'b1, ST_MISSING, 7'd0},
        '{OP_INSERT, 64'd0,     KEY_MAX, 5'd1,  1'b1, ST_OK,      7'd1},
        '{OP_INSERT, KEY_MAX,   64'd0,   5'd1,  1'b1, ST_OK,      7'd2},
        '{OP_INSERT, NAME_JOHN, PHONE_A, 5'd1,  1'b0, ST_OK,      7'd0},
        '{OP_INSERT, NAME_JOHN, PHONE_B, 5'd1,  1'b0, ST_OK,      7'd0},
        '{OP_FIND,   NAME_JOHN, 64'd0,   5'd1,  1'b0, ST_OK,      7'd0},
        '{OP_LIST,   64'd0,     64'd0,   5'd1,  1'b0, ST_OK,      7'd0},
        '{OP_DELETE, NAME_JOHN, 64'd0,   5'd1,  1'b0, ST_OK,      7'd0},
        '{OP_FIND,   NAME_JOHN, 64'd0,   5'd1,  1'b0, ST_OK,      7'd0},
        '{OP_INSERT, NAME_MA,   PHONE_A, 5'd13, 1'b0, ST_OK,      7'd0},
        '{OP_INSERT, NAME_ZZ,   PHONE_B, 5'd1,  1'b1, ST_FULL,    7'd16},
        '{OP_FIND,   NAME_ZZ,   64'd0,   5'd1,  1'b1, ST_MISSING, 7'd16},
        '{OP_FIND,   KEY_MAX,   64'd0,   5'd1,  1'b0, ST_OK,      7'd0},
        '{OP_DELETE, KEY_MAX,   64'd0,   5'd1,  1'b1, ST_OK,      7'd15},
        '{OP_LIST,   64'd0,     64'd0,   5'd1,  1'b0, ST_OK,      7'd0}
    };

    function automatic void predict_table_reply(op_t op, logic [63:0] key,
                                                logic [63:0] value);
        int     pos;
        reply_t r;
        r.status      = ST_OK;
        r.entry_key   = '0;
        r.entry_value = '0;
        r.last        = 1'b1;
        case (op)
            OP_INSERT:
            begin
                if (tbl_held >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    pos = tbl_held;
                    while (pos > 0 && tbl_key[pos-1] > key)
                    begin
                        tbl_key[pos] = tbl_key[pos-1];
                        tbl_val[pos] = tbl_val[pos-1];
                        pos--;
                    end
                    tbl_key[pos] = key;
                    tbl_val[pos] = value;
                    tbl_held++;
                end
                r.entries_held = 7'(tbl_held);
                due_replies.push_back(r);
            end
            OP_FIND, OP_DELETE:
            begin
                pos = 0;
                while (pos < tbl_held && tbl_key[pos] != key)
                    pos++;
                if (pos == tbl_held)
                    r.status = ST_MISSING;
                else if (op == OP_FIND)
                begin
                    r.entry_key   = tbl_key[pos];
                    r.entry_value = tbl_val[pos];
                end
                else
                begin
                    for (int i = pos; i + 1 < tbl_held; i++)
                    begin
                        tbl_key[i] = tbl_key[i+1];
                        tbl_val[i] = tbl_val[i+1];
                    end
                    tbl_held--;
                end
                r.entries_held = 7'(tbl_held);
                due_replies.push_back(r);
            end
            default:
            begin
                r.entries_held = 7'(tbl_held);
                if (tbl_held == 0)
                begin
                    r.status = ST_EMPTY;
                    due_replies.push_back(r);
                end
                else
                    for (int i = 0; i < tbl_held; i++)
                    begin
                        r.entry_key   = tbl_key[i];
                        r.entry_value = tbl_val[i];
                        r.last        = (i + 1 == tbl_held);
                        due_replies.push_back(r);
                    end
            end
        endcase
    endfunction

    // mostly short gaps, a few long ones, and calm stretches with none
    function automatic int pick_idle(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            calm = $urandom_range(10, 30);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] fresh_key();
        logic [63:0] k;
        int          pick;
        int          len;
        pick = $urandom_range(0, 19);
        k = '0;
        if (pick < 10)
        begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
                k[63 - 8*i -: 8] = 8'h61 + 8'($urandom_range(0, 25));
        end
        else if (pick < 15)
            k = {$urandom, $urandom};
        else if (pick < 18 && tbl_held > 0)
            k = tbl_key[$urandom_range(0, tbl_held - 1)] + ((pick == 15) ? -64'd1 : 64'd1);
        else if (pick == 18)
            k = KEY_MAX;
        return k;
    endfunction

    function automatic logic [63:0] stored_key();
        if (tbl_held == 0)
            return fresh_key();
        return tbl_key[$urandom_range(0, tbl_held - 1)];
    endfunction

    task automatic send_request(input op_t op, input logic [63:0] key,
                                input logic [63:0] value, input logic typed,
                                input status_t want_status, input logic [6:0] want_held);
        reply_t fixed;
        int     gap;
        req.valid     <= 1'b1;
        req.operation <= op;
        req.key       <= key;
        req.value     <= value;
        do
            @(posedge clk);
        while (!req.ready);
        predict_table_reply(op, key, value);
        if (typed)
        begin
            void'(due_replies.pop_back());
            fixed.status       = want_status;
            fixed.entry_key    = '0;
            fixed.entry_value  = '0;
            fixed.entries_held = want_held;
            fixed.last         = 1'b1;
            due_replies.push_back(fixed);
        end
        op_count[op]++;
        items_sent++;
        gap = pick_idle(send_calm);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random(input op_t op, input logic [63:0] key);
        send_request(op, key, {$urandom, $urandom}, 1'b0, ST_OK, 7'd0);
    endtask

    task automatic hold_until_replied();
        req.valid <= 1'b0;
        do
            @(posedge clk);
        while (due_replies.size() != 0);
    endtask

    task automatic check_reply();
        reply_t got;
        reply_t want;
        got.status       = status_t'(rep.status);
        got.entry_key    = rep.entry_key;
        got.entry_value  = rep.entry_value;
        got.entries_held = rep.entries_held;
        got.last         = rep.last;
        replies_checked++;
        case (got.status)
            ST_FULL:    seen_full++;
            ST_MISSING: seen_missing++;
            ST_EMPTY:   seen_empty++;
            default:    ;
        endcase
        if (due_replies.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("%0t: unexpected reply status=%0d key=%h value=%h held=%0d last=%b",
                         $realtime, got.status, got.entry_key, got.entry_value,
                         got.entries_held, got.last);
            return;
        end
        want = due_replies.pop_front();
        if (got.status !== want.status || got.entry_key !== want.entry_key
            || got.entry_value !== want.entry_value
            || got.entries_held !== want.entries_held || got.last !== want.last)
        begin
            errors++;
            if (errors <= 10)
            begin
                $display("%0t: reply mismatch", $realtime);
                $display("  expected status=%0d key=%h value=%h held=%0d last=%b",
                         want.status, want.entry_key, want.entry_value,
                         want.entries_held, want.last);
                $display("  actual   status=%0d key=%h value=%h held=%0d last=%b",
                         got.status, got.entry_key, got.entry_value,
                         got.entries_held, got.last);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rep.valid === 1'b1 && rep.ready === 1'b1)
            check_reply();
        if (stall_left > 0)
        begin
            rep.ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            rep.ready  <= 1'b1;
            stall_left <= pick_idle(sink_calm);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((req.valid === 1'b1 && req.ready === 1'b1)
                || (rep.valid === 1'b1 && rep.ready === 1'b1))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_MAX)
            begin
                $display("%0t: no item moved for %0d cycles", $realtime, quiet);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int   mode;
        int   r;
        bit   paused;
        op_t  op;
        errors          = 0;
        replies_checked = 0;
        op_count        = '{0, 0, 0, 0};
        seen_full       = 0;
        seen_missing    = 0;
        seen_empty      = 0;
        items_sent      = 0;
        send_calm       = 0;
        sink_calm       = 0;
        stall_left      = 0;
        quiet           = 0;
        tbl_held        = 0;
        paused          = 1'b0;
        rst_n           = 1'b0;
        req.valid       = 1'b0;
        req.operation   = OP_INSERT;
        req.key         = '0;
        req.value       = '0;
        rep.ready       = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int s = 0; s < NPLAN; s++)
            for (int i = 0; i < plan[s].reps; i++)
                send_request(plan[s].op, plan[s].key + (64'(i) << 48), plan[s].value + 64'(i),
                             plan[s].typed, plan[s].want_status, plan[s].want_held);
        hold_until_replied();

        while (items_sent < RAND_ITEMS)
        begin
            if (!paused && items_sent > RAND_ITEMS / 2)
            begin
                hold_until_replied();
                paused = 1'b1;
            end
            mode = $urandom_range(0, 19);
            if (mode == 0)
            begin
                while (tbl_held < DEPTH)
                    send_random(OP_INSERT, fresh_key());
                send_random(OP_INSERT, fresh_key());
                send_random(OP_LIST, fresh_key());
            end
            else if (mode == 1)
            begin
                while (tbl_held > 0)
                    send_random(OP_DELETE, stored_key());
                send_random(OP_LIST, fresh_key());
                send_random(OP_FIND, fresh_key());
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 35)
                    op = OP_INSERT;
                else if (r < 60)
                    op = OP_FIND;
                else if (r < 88)
                    op = OP_DELETE;
                else
                    op = OP_LIST;
                if ((op == OP_INSERT) ? ($urandom_range(0, 9) < 3) : ($urandom_range(0, 9) < 7))
                    send_random(op, stored_key());
                else
                    send_random(op, fresh_key());
            end
        end

        req.valid <= 1'b0;
        while (due_replies.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 8) @(posedge clk);

        $display("Sent %0d items: %0d insert, %0d find, %0d delete, %0d list; %0d replies checked",
                 items_sent, op_count[OP_INSERT], op_count[OP_FIND], op_count[OP_DELETE],
                 op_count[OP_LIST], replies_checked);
        $display("Replies by status: full %0d, not found %0d, empty %0d; mismatches %0d",
                 seen_full, seen_missing, seen_empty, errors);
        if (errors == 0 && due_replies.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
